// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication: whenever ante holds, cons holds too.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication: whenever ante holds, cons holds in the following cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ===== design/pst_pkg.sv =====
// ----------------------------------------------------------------------------
// pst_pkg
// Types and codes shared by the profile strip triangulator modules.
// ----------------------------------------------------------------------------
package pst_pkg;

  localparam int unsigned VERTEX_W  = 16;
  localparam int unsigned PROFILE_W = 5;

  typedef enum logic {
    OP_APPEND  = 1'b0,
    OP_CONNECT = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_TRIANGLE  = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_UNDEFINED = 2'd3
  } result_status_t;

  // Which profile boundary a start-table read fetches.
  typedef enum logic [1:0] {
    TS_START_A = 2'd0,
    TS_END_A   = 2'd1,
    TS_START_B = 2'd2,
    TS_END_B   = 2'd3
  } tbl_sel_t;

  // Which walk pointer addresses the vertex store.
  typedef enum logic {
    VS_A = 1'b0,
    VS_B = 1'b1
  } vsel_t;

  typedef struct packed {
    op_t                  operation;
    logic [VERTEX_W-1:0]  vertex_index;
    logic                 closes_profile;
    logic [PROFILE_W-1:0] profile_a;
    logic [PROFILE_W-1:0] profile_b;
    logic                 even_pattern;
  } req_item_t;

  typedef struct packed {
    logic [VERTEX_W-1:0] corner_first;
    logic [VERTEX_W-1:0] corner_second;
    logic [VERTEX_W-1:0] corner_third;
    result_status_t      status;
    logic                last;
  } res_item_t;

  typedef struct packed {
    logic           latch;
    logic           append;
    logic           tbl_rd;
    tbl_sel_t       tbl_sel;
    logic           calc;
    logic           vrd;
    vsel_t          vsel;
    logic           shift;
    logic           push;
    logic           push_second;
    logic           step;
    logic           fin;
    result_status_t fin_status;
  } dp_cmd_t;

  typedef struct packed {
    op_t  operation;
    logic overflow;
    logic undefined;
    logic no_pairs;
    logic last_pair;
    logic hit_first;
    logic hit_second;
    logic can_push;
    logic out_free;
    logic pend_valid;
  } dp_status_t;

endpackage

// ===== design/pst_req_if.sv =====
// ----------------------------------------------------------------------------
// pst_req_if
// Request channel: append and connect requests with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pst_req_if;
  logic                            valid;
  logic                            ready;
  logic                            operation;
  logic [pst_pkg::VERTEX_W-1:0]    vertex_index;
  logic                            closes_profile;
  logic [pst_pkg::PROFILE_W-1:0]   profile_a;
  logic [pst_pkg::PROFILE_W-1:0]   profile_b;
  logic                            even_pattern;

  modport source (
    output valid, operation, vertex_index, closes_profile, profile_a, profile_b,
           even_pattern,
    input  ready
  );

  modport sink (
    input  valid, operation, vertex_index, closes_profile, profile_a, profile_b,
           even_pattern,
    output ready
  );
endinterface

// ===== design/pst_res_if.sv =====
// ----------------------------------------------------------------------------
// pst_res_if
// Result channel: triangles and status words with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pst_res_if;
  logic                         valid;
  logic                         ready;
  logic [pst_pkg::VERTEX_W-1:0] corner_first;
  logic [pst_pkg::VERTEX_W-1:0] corner_second;
  logic [pst_pkg::VERTEX_W-1:0] corner_third;
  logic [1:0]                   status;
  logic                         last;

  modport source (
    output valid, corner_first, corner_second, corner_third, status, last,
    input  ready
  );

  modport sink (
    input  valid, corner_first, corner_second, corner_third, status, last,
    output ready
  );
endinterface

// ===== design/pst_ctrl.sv =====
// ----------------------------------------------------------------------------
// pst_ctrl
// Sequencer for append and connect requests; drives datapath commands.
// ----------------------------------------------------------------------------
module pst_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  pst_pkg::dp_status_t sts,
  output pst_pkg::dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_TEA, S_TSB, S_TEB, S_TWAIT, S_CALC,
    S_PA, S_PB, S_RB, S_RD, S_T1, S_T2, S_FIN
  } state_t;

  state_t                   state;
  state_t                   state_next;
  pst_pkg::result_status_t  fin_code;
  pst_pkg::result_status_t  fin_code_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      fin_code <= pst_pkg::ST_EMPTY;
    end else begin
      state    <= state_next;
      fin_code <= fin_code_next;
    end
  end

  always_comb begin
    state_next     = state;
    fin_code_next  = fin_code;
    req_ready      = 1'b0;
    cmd            = '0;
    cmd.fin_status = fin_code;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.operation == pst_pkg::OP_APPEND) begin
          if (sts.overflow) begin
            fin_code_next = pst_pkg::ST_OVERFLOW;
            state_next    = S_FIN;
          end else begin
            cmd.append = 1'b1;
            state_next = S_IDLE;
          end
        end else if (sts.undefined) begin
          fin_code_next = pst_pkg::ST_UNDEFINED;
          state_next    = S_FIN;
        end else begin
          cmd.tbl_rd  = 1'b1;
          cmd.tbl_sel = pst_pkg::TS_START_A;
          state_next  = S_TEA;
        end
      end
      S_TEA: begin
        cmd.tbl_rd  = 1'b1;
        cmd.tbl_sel = pst_pkg::TS_END_A;
        state_next  = S_TSB;
      end
      S_TSB: begin
        cmd.tbl_rd  = 1'b1;
        cmd.tbl_sel = pst_pkg::TS_START_B;
        state_next  = S_TEB;
      end
      S_TEB: begin
        cmd.tbl_rd  = 1'b1;
        cmd.tbl_sel = pst_pkg::TS_END_B;
        state_next  = S_TWAIT;
      end
      S_TWAIT: begin
        state_next = S_CALC;
      end
      S_CALC: begin
        cmd.calc      = 1'b1;
        fin_code_next = pst_pkg::ST_EMPTY;
        state_next    = sts.no_pairs ? S_FIN : S_PA;
      end
      S_PA: begin
        cmd.vrd    = 1'b1;
        cmd.vsel   = pst_pkg::VS_A;
        state_next = S_PB;
      end
      S_PB: begin
        cmd.vrd    = 1'b1;
        cmd.vsel   = pst_pkg::VS_B;
        state_next = S_RB;
      end
      S_RB: begin
        cmd.shift  = 1'b1;
        cmd.vrd    = 1'b1;
        cmd.vsel   = pst_pkg::VS_A;
        state_next = S_RD;
      end
      S_RD: begin
        cmd.vrd    = 1'b1;
        cmd.vsel   = pst_pkg::VS_B;
        state_next = S_T1;
      end
      S_T1: begin
        if (!sts.hit_first) begin
          state_next = S_T2;
        end else if (sts.can_push) begin
          cmd.push   = 1'b1;
          state_next = S_T2;
        end
      end
      S_T2: begin
        if (!sts.hit_second || sts.can_push) begin
          cmd.push        = sts.hit_second;
          cmd.push_second = 1'b1;
          if (sts.last_pair) begin
            state_next = S_FIN;
          end else begin
            cmd.step   = 1'b1;
            state_next = S_RB;
          end
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/pst_dp.sv =====
// ----------------------------------------------------------------------------
// pst_dp
// Datapath: vertex store, profile start table, walk pointers and result regs.
// ----------------------------------------------------------------------------
module pst_dp #(
  parameter int unsigned MAX_PROFILES         = 32,
  parameter int unsigned MAX_PROFILE_VERTICES = 32,
  parameter int unsigned STORE_DEPTH          = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  pst_pkg::req_item_t  req_item,
  output pst_pkg::res_item_t  res_item,
  output logic                res_valid,
  input  logic                res_ready,
  input  pst_pkg::dp_cmd_t    cmd,
  output pst_pkg::dp_status_t sts
);

  localparam int unsigned CW   = $clog2(MAX_PROFILES + 1);
  localparam int unsigned OLW  = $clog2(MAX_PROFILE_VERTICES + 1);
  localparam int unsigned PW   = $clog2(MAX_PROFILE_VERTICES);
  localparam int unsigned SW   = $clog2(STORE_DEPTH + 1);
  localparam int unsigned AW   = $clog2(STORE_DEPTH);
  localparam int unsigned CMPW = (CW > pst_pkg::PROFILE_W) ? CW : pst_pkg::PROFILE_W;
  localparam int unsigned VW   = pst_pkg::VERTEX_W;

  pst_pkg::req_item_t req_q;

  logic [CW-1:0]  count;
  logic [OLW-1:0] open_len;
  logic [SW-1:0]  open_base;
  logic [SW:0]    append_addr;
  logic [SW-1:0]  close_start;

  logic [VW-1:0] vmem [STORE_DEPTH];
  logic [SW-1:0] tbl_mem [MAX_PROFILES + 1];

  logic [CW-1:0]     tbl_addr;
  logic [SW-1:0]     tbl_q;
  logic              tbl_zero;
  logic              tbl_cap;
  pst_pkg::tbl_sel_t tbl_tgt;
  logic [SW-1:0]     start_a, end_a, start_b, end_b;
  logic [SW-1:0]     len_a, len_b, len_min;

  logic [PW-1:0] pairs_left;
  logic [AW-1:0] ptr_a, ptr_b, vaddr;
  logic [VW-1:0] vq, va, vb, vc;

  pst_pkg::res_item_t tri_first, tri_second, tri_new;
  pst_pkg::res_item_t pend;
  pst_pkg::res_item_t fin_item;
  logic               pend_valid;
  logic               out_free;

  // Request latch.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_q <= req_item;
    end
  end

  // Open profile bookkeeping.
  assign append_addr = {1'b0, open_base} + (SW + 1)'(open_len);
  assign close_start = append_addr[SW-1:0] + SW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      open_len  <= '0;
      open_base <= '0;
    end else if (cmd.append) begin
      if (req_q.closes_profile) begin
        count     <= count + CW'(1);
        open_len  <= '0;
        open_base <= close_start;
      end else begin
        open_len <= open_len + OLW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      vmem[append_addr[AW-1:0]] <= req_q.vertex_index;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.append && req_q.closes_profile) begin
      tbl_mem[count + CW'(1)] <= close_start;
    end
  end

  // Start table reads; entry zero is never written and reads as zero.
  always_comb begin
    case (cmd.tbl_sel)
      pst_pkg::TS_START_A: tbl_addr = CW'(req_q.profile_a);
      pst_pkg::TS_END_A:   tbl_addr = CW'(req_q.profile_a) + CW'(1);
      pst_pkg::TS_START_B: tbl_addr = CW'(req_q.profile_b);
      pst_pkg::TS_END_B:   tbl_addr = CW'(req_q.profile_b) + CW'(1);
      default:             tbl_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.tbl_rd) begin
      tbl_q    <= tbl_mem[tbl_addr];
      tbl_zero <= (tbl_addr == '0);
      tbl_tgt  <= cmd.tbl_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tbl_cap <= 1'b0;
    end else begin
      tbl_cap <= cmd.tbl_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_cap) begin
      case (tbl_tgt)
        pst_pkg::TS_START_A: start_a <= tbl_zero ? '0 : tbl_q;
        pst_pkg::TS_END_A:   end_a   <= tbl_zero ? '0 : tbl_q;
        pst_pkg::TS_START_B: start_b <= tbl_zero ? '0 : tbl_q;
        pst_pkg::TS_END_B:   end_b   <= tbl_zero ? '0 : tbl_q;
        default: ;
      endcase
    end
  end

  assign len_a   = end_a - start_a;
  assign len_b   = end_b - start_b;
  assign len_min = (len_a < len_b) ? len_a : len_b;

  // Walk pointers and pair counter.
  assign vaddr = (cmd.vsel == pst_pkg::VS_B) ? ptr_b : ptr_a;

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      ptr_a      <= AW'(start_a);
      ptr_b      <= AW'(start_b);
      pairs_left <= PW'(len_min - SW'(1));
    end else begin
      if (cmd.vrd && cmd.vsel == pst_pkg::VS_A) begin
        ptr_a <= ptr_a + AW'(1);
      end
      if (cmd.vrd && cmd.vsel == pst_pkg::VS_B) begin
        ptr_b <= ptr_b + AW'(1);
      end
      if (cmd.step) begin
        pairs_left <= pairs_left - PW'(1);
      end
    end
  end

  // Vertex reads: vq is the registered read word. A read of profile B moves
  // the profile A word into vb, so after a pair of reads vb holds b and vq d.
  always_ff @(posedge clk) begin
    if (cmd.vrd) begin
      vq <= vmem[vaddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.vrd && cmd.vsel == pst_pkg::VS_B) begin
      vb <= vq;
    end
    if (cmd.shift) begin
      va <= vb;
      vc <= vq;
    end
  end

  // Candidate triangles of the current quad.
  always_comb begin
    tri_first  = '0;
    tri_second = '0;
    if (req_q.even_pattern) begin
      tri_first.corner_first   = va;
      tri_first.corner_second  = vq;
      tri_first.corner_third   = vc;
      tri_second.corner_first  = va;
      tri_second.corner_second = vb;
      tri_second.corner_third  = vq;
    end else begin
      tri_first.corner_first   = va;
      tri_first.corner_second  = vb;
      tri_first.corner_third   = vc;
      tri_second.corner_first  = vb;
      tri_second.corner_second = vq;
      tri_second.corner_third  = vc;
    end
    tri_first.status  = pst_pkg::ST_TRIANGLE;
    tri_second.status = pst_pkg::ST_TRIANGLE;
  end

  assign tri_new  = cmd.push_second ? tri_second : tri_first;
  assign out_free = !res_valid || res_ready;

  // One triangle is held back so that the final one can carry last.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.fin) begin
      pend_valid <= 1'b0;
    end else if (cmd.push) begin
      pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      pend <= tri_new;
    end
  end

  // The closing result is the held-back triangle, or else a status word.
  always_comb begin
    if (pend_valid) begin
      fin_item = pend;
    end else begin
      fin_item        = '0;
      fin_item.status = cmd.fin_status;
    end
    fin_item.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.fin || (cmd.push && pend_valid)) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      res_item <= fin_item;
    end else if (cmd.push && pend_valid) begin
      res_item <= pend;
    end
  end

  // Status toward the controller.
  always_comb begin
    sts.operation  = req_q.operation;
    sts.overflow   = (count >= CW'(MAX_PROFILES))
                  || (open_len >= OLW'(MAX_PROFILE_VERTICES))
                  || (append_addr >= (SW + 1)'(STORE_DEPTH));
    sts.undefined  = (CMPW'(req_q.profile_a) >= CMPW'(count))
                  || (CMPW'(req_q.profile_b) >= CMPW'(count));
    sts.no_pairs   = (len_min <= SW'(1));
    sts.last_pair  = (pairs_left == PW'(1));
    sts.hit_first  = (va != vc);
    sts.hit_second = (vb != vq);
    sts.can_push   = !pend_valid || out_free;
    sts.out_free   = out_free;
    sts.pend_valid = pend_valid;
  end

endmodule

// ===== design/profile_strip_triangulator.sv =====
// ----------------------------------------------------------------------------
// profile_strip_triangulator
// Stores vertex-index profiles and stitches two of them into index triangles.
// ----------------------------------------------------------------------------
// Usage: requests arrive on req. An append request (operation 0) adds
// vertex_index to the open profile; closes_profile ends that profile. An
// append gives no result unless it overflows the store, the profile length
// limit or the profile count, in which case one overflow status word comes
// back. A connect request (operation 1) walks profiles profile_a and
// profile_b pairwise and returns a triangle on res for every quad half whose
// corner pair differs, with last set on the final one, or a single status
// word when no triangle comes out or a profile is undefined.
// Sequencing: one request is handled at a time. An append is latched, then
// checked and stored. A connect reads the start table and sets up, primes
// the vertex walk, then reads the next vertex of each profile for every pair,
// paced by the single read port of the vertex store, and then finishes.
// Reset clears the profile count, the open profile and the result register;
// the vertex store and start table need no clearing. When res is stalled,
// the walk waits in front of the second pending triangle; nothing is lost.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module profile_strip_triangulator #(
  parameter int unsigned MAX_PROFILES         = 32,
  parameter int unsigned MAX_PROFILE_VERTICES = 32,
  parameter int unsigned STORE_DEPTH          = 1024
) (
  input logic    clk,
  input logic    rst,
  pst_req_if.sink   req,
  pst_res_if.source res
);

  pst_pkg::req_item_t  req_item;
  pst_pkg::res_item_t  res_item;
  logic                res_valid;
  pst_pkg::dp_cmd_t    cmd;
  pst_pkg::dp_status_t sts;

  // The request fields are packed into one item for the datapath latch.
  always_comb begin
    req_item.operation      = pst_pkg::op_t'(req.operation);
    req_item.vertex_index   = req.vertex_index;
    req_item.closes_profile = req.closes_profile;
    req_item.profile_a      = req.profile_a;
    req_item.profile_b      = req.profile_b;
    req_item.even_pattern   = req.even_pattern;
  end

  // The controller sequences each request; the datapath owns all storage.
  pst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pst_dp #(
    .MAX_PROFILES         (MAX_PROFILES),
    .MAX_PROFILE_VERTICES (MAX_PROFILE_VERTICES),
    .STORE_DEPTH          (STORE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_item  (req_item),
    .res_item  (res_item),
    .res_valid (res_valid),
    .res_ready (res.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // The result register drives the result channel directly.
  assign res.valid         = res_valid;
  assign res.corner_first  = res_item.corner_first;
  assign res.corner_second = res_item.corner_second;
  assign res.corner_third  = res_item.corner_third;
  assign res.status        = res_item.status;
  assign res.last          = res_item.last;

  // A status word always closes its request.
  `ASSERT_IMPLIES(a_status_is_last, clk, rst, res.valid && res.status != pst_pkg::ST_TRIANGLE, res.last, "status word without last")
  // No triangle may be held back once the block is ready for a new request.
  `ASSERT_IMPLIES(a_idle_no_pending, clk, rst, req.ready, !sts.pend_valid, "pending triangle while idle")
  // An accepted request leaves the block busy in the cycle after it is taken.
  `ASSERT_NEXT(a_accept_busy, clk, rst, req.valid && req.ready, !req.ready, "ready right after accept")
  // A finish command only issues when the result register can take it.
  `ASSERT_IMPLIES(a_fin_has_room, clk, rst, cmd.fin, sts.out_free, "finish while result register is full")

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for profile_strip_triangulator. Profiles are built
// from append requests and stitched by connect requests. A shadow copy of
// the profile store predicts every triangle and status word, and each
// result is compared field by field as it is handed over.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Sizes of the instance under test (its defaults).
  localparam int unsigned MAX_PROFILES         = 32;
  localparam int unsigned MAX_PROFILE_VERTICES = 32;
  localparam int unsigned STORE_DEPTH          = 1024;

  // Long enough for a connect over 31 pairs, so this covers any walk that
  // could still be running once the last result came back.
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned RANDOM_REQUESTS = 120;
  // Length of the long result-side stall, in cycles.
  localparam int unsigned LONG_HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pst_req_if req_ch ();
  pst_res_if res_ch ();

  profile_strip_triangulator i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  initial begin : clock_gen
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Shadow of the profile store. It is updated when a request is accepted,
  // so the expected results are queued before the block can produce them.
  // --------------------------------------------------------------------------
  logic [pst_pkg::VERTEX_W-1:0] shadow_vertex [0:STORE_DEPTH-1];
  logic [10:0]                  shadow_start  [0:MAX_PROFILES];
  int unsigned                  shadow_closed   = 0;
  int unsigned                  shadow_open_len = 0;

  // Triangles and status words still owed by the block, oldest first.
  pst_pkg::res_item_t strip_output_due [$];

  int unsigned mismatch_count = 0;

  // Each increment asks the result side for one long hold-off.
  int unsigned hold_requests = 0;

  // Idle phases: each side alternates between stretches with random gaps
  // and stretches that run at full rate.
  int unsigned req_phase_left = 0;
  int unsigned req_gap_max    = 0;
  int unsigned res_phase_left = 0;
  int unsigned res_gap_max    = 0;

  function automatic pst_pkg::res_item_t status_word(input pst_pkg::result_status_t code);
    pst_pkg::res_item_t word;
    word.corner_first  = '0;
    word.corner_second = '0;
    word.corner_third  = '0;
    word.status        = code;
    word.last          = 1'b1;
    return word;
  endfunction

  function automatic pst_pkg::res_item_t facet_word(input logic [pst_pkg::VERTEX_W-1:0] p,
                                                    input logic [pst_pkg::VERTEX_W-1:0] q,
                                                    input logic [pst_pkg::VERTEX_W-1:0] r);
    pst_pkg::res_item_t word;
    word.corner_first  = p;
    word.corner_second = q;
    word.corner_third  = r;
    word.status        = pst_pkg::ST_TRIANGLE;
    word.last          = 1'b0;
    return word;
  endfunction

  // Appends one result to the list of results still owed.
  function automatic void owe_result(input pst_pkg::res_item_t word);
    strip_output_due = {strip_output_due, word};
  endfunction

  // Works out what one accepted request owes and updates the shadow store.
  function automatic void predict_strip_output(input pst_pkg::req_item_t item);
    int unsigned base, addr, pa, pb, sa, sb, len_a, len_b, pairs, k;
    logic [pst_pkg::VERTEX_W-1:0] a, b, c, d;
    pst_pkg::res_item_t facets [$];
    pst_pkg::res_item_t word;
    if (item.operation == pst_pkg::OP_APPEND) begin
      // A full profile count or a full open profile drops the whole
      // request, the closing marker included.
      if (shadow_closed >= MAX_PROFILES || shadow_open_len >= MAX_PROFILE_VERTICES) begin
        owe_result(status_word(pst_pkg::ST_OVERFLOW));
        return;
      end
      base = shadow_start[shadow_closed];
      addr = base + shadow_open_len;
      if (addr >= STORE_DEPTH) begin
        owe_result(status_word(pst_pkg::ST_OVERFLOW));
        return;
      end
      shadow_vertex[addr] = item.vertex_index;
      shadow_open_len++;
      if (item.closes_profile) begin
        shadow_start[shadow_closed + 1] = 11'(base + shadow_open_len);
        shadow_closed++;
        shadow_open_len = 0;
      end
      return;
    end
    pa = item.profile_a;
    pb = item.profile_b;
    if (pa >= shadow_closed || pb >= shadow_closed) begin
      owe_result(status_word(pst_pkg::ST_UNDEFINED));
      return;
    end
    sa    = shadow_start[pa];
    sb    = shadow_start[pb];
    len_a = shadow_start[pa + 1] - sa;
    len_b = shadow_start[pb + 1] - sb;
    pairs = (len_a < len_b) ? len_a : len_b;
    pairs = (pairs > 0) ? pairs - 1 : 0;
    for (k = 0; k < pairs; k++) begin
      a = shadow_vertex[sa + k];
      b = shadow_vertex[sa + k + 1];
      c = shadow_vertex[sb + k];
      d = shadow_vertex[sb + k + 1];
      // Each quad half is dropped when the corner pair it spans collapses.
      if (item.even_pattern) begin
        if (a != c) facets = {facets, facet_word(a, d, c)};
        if (b != d) facets = {facets, facet_word(a, b, d)};
      end else begin
        if (a != c) facets = {facets, facet_word(a, b, c)};
        if (b != d) facets = {facets, facet_word(b, d, c)};
      end
    end
    if (facets.size() == 0) begin
      owe_result(status_word(pst_pkg::ST_EMPTY));
      return;
    end
    foreach (facets[n]) begin
      word = facets[n];
      word.last = (n == facets.size() - 1);
      owe_result(word);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Request builders. Fields that the operation does not use carry random
  // values, since the block has to ignore them.
  // --------------------------------------------------------------------------
  function automatic pst_pkg::req_item_t append_item(input logic [pst_pkg::VERTEX_W-1:0] vertex,
                                                     input logic closes);
    pst_pkg::req_item_t item;
    item.operation      = pst_pkg::OP_APPEND;
    item.vertex_index   = vertex;
    item.closes_profile = closes;
    item.profile_a      = pst_pkg::PROFILE_W'($urandom);
    item.profile_b      = pst_pkg::PROFILE_W'($urandom);
    item.even_pattern   = 1'($urandom);
    return item;
  endfunction

  function automatic pst_pkg::req_item_t connect_item(input int unsigned pa,
                                                      input int unsigned pb,
                                                      input logic even);
    pst_pkg::req_item_t item;
    item.operation      = pst_pkg::OP_CONNECT;
    item.vertex_index   = pst_pkg::VERTEX_W'($urandom);
    item.closes_profile = 1'($urandom);
    item.profile_a      = pst_pkg::PROFILE_W'(pa);
    item.profile_b      = pst_pkg::PROFILE_W'(pb);
    item.even_pattern   = even;
    return item;
  endfunction

  // Vertex values lean on a tiny set so that corner pairs often coincide,
  // with the range ends and fully random values mixed in.
  function automatic logic [pst_pkg::VERTEX_W-1:0] draw_vertex();
    case ($urandom_range(0, 3))
      0, 1:    return pst_pkg::VERTEX_W'($urandom_range(0, 3));
      2:       return $urandom_range(0, 1) ? '1 : '0;
      default: return pst_pkg::VERTEX_W'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Request side. Inputs change on the falling edge; the request is taken
  // at the rising edge where valid and ready are both high. Valid stays
  // high after a request so that back-to-back requests need no dip.
  // --------------------------------------------------------------------------
  task automatic send_request(input pst_pkg::req_item_t item);
    int unsigned gap;
    if (req_phase_left == 0) begin
      req_phase_left = $urandom_range(5, 40);
      req_gap_max    = ($urandom_range(0, 3) == 0) ? 0 : 19;
    end
    req_phase_left--;
    gap = $urandom_range(0, req_gap_max);
    @(negedge clk);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid          <= 1'b1;
    req_ch.operation      <= item.operation;
    req_ch.vertex_index   <= item.vertex_index;
    req_ch.closes_profile <= item.closes_profile;
    req_ch.profile_a      <= item.profile_a;
    req_ch.profile_b      <= item.profile_b;
    req_ch.even_pattern   <= item.even_pattern;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    predict_strip_output(item);
  endtask

  // Drops valid and waits until every owed result has come back, then a
  // while longer so that a stray extra result would still be caught.
  task automatic await_drain();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (strip_output_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Result side: draws a gap for every result, honors a requested hold-off,
  // and checks each result against the oldest expectation.
  // --------------------------------------------------------------------------
  task automatic compare_field(input string name, input logic [pst_pkg::VERTEX_W-1:0] want,
                               input logic [pst_pkg::VERTEX_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  initial begin : result_sink
    pst_pkg::res_item_t want;
    int unsigned gap;
    int unsigned holds_served;
    holds_served = 0;
    res_ch.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
      end
      if (res_phase_left == 0) begin
        res_phase_left = $urandom_range(5, 40);
        res_gap_max    = ($urandom_range(0, 3) == 0) ? 0 : 19;
      end
      res_phase_left--;
      gap = $urandom_range(0, res_gap_max);
      if (gap != 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (res_ch.valid !== 1'b1);
      if (strip_output_due.size() == 0) begin
        $error("unexpected result: corners %0d %0d %0d, status %0d, last %0d",
               res_ch.corner_first, res_ch.corner_second, res_ch.corner_third,
               res_ch.status, res_ch.last);
        mismatch_count++;
      end else begin
        want = strip_output_due.pop_front();
        compare_field("corner_first", want.corner_first, res_ch.corner_first);
        compare_field("corner_second", want.corner_second, res_ch.corner_second);
        compare_field("corner_third", want.corner_third, res_ch.corner_third);
        compare_field("status", pst_pkg::VERTEX_W'(want.status),
                      pst_pkg::VERTEX_W'(res_ch.status));
        compare_field("last", pst_pkg::VERTEX_W'(want.last),
                      pst_pkg::VERTEX_W'(res_ch.last));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // With nothing stored yet, every profile number is undefined.
  task automatic test_undefined_before_profiles();
    send_request(connect_item(0, 0, 1'b1));
    send_request(connect_item(31, 31, 1'b0));
  endtask

  // Four short profiles, laid out so that each quad half is dropped once:
  //   profile 0: 10 20 30     profile 1: 10 21 30
  //   profile 2: 0 65535      profile 3: 65535 (single vertex)
  // A single-vertex profile gives no pairs, and a profile stitched to
  // itself collapses every quad, so both come back as empty.
  task automatic test_small_strips();
    send_request(append_item(16'd10, 1'b0));
    send_request(append_item(16'd20, 1'b0));
    send_request(append_item(16'd30, 1'b1));
    send_request(append_item(16'd10, 1'b0));
    send_request(append_item(16'd21, 1'b0));
    send_request(append_item(16'd30, 1'b1));
    send_request(append_item(16'h0000, 1'b0));
    send_request(append_item(16'hFFFF, 1'b1));
    send_request(append_item(16'hFFFF, 1'b1));
    send_request(connect_item(0, 1, 1'b1));
    send_request(connect_item(0, 1, 1'b0));
    send_request(connect_item(2, 3, 1'b1));
    send_request(connect_item(2, 2, 1'b0));
    send_request(connect_item(0, 2, 1'b1));
    send_request(connect_item(2, 0, 1'b0));
    // Profile 4 does not exist yet, on either side of the request.
    send_request(connect_item(1, 4, 1'b1));
    send_request(connect_item(4, 0, 1'b0));
  endtask

  // Two profiles at the length limit, so each walk covers 31 pairs and
  // usually yields the full 62 triangles.
  task automatic test_longest_walk();
    int unsigned first, n;
    first = shadow_closed;
    repeat (2) begin
      for (n = 0; n < MAX_PROFILE_VERTICES; n++)
        send_request(append_item(pst_pkg::VERTEX_W'($urandom),
                                 n == MAX_PROFILE_VERTICES - 1));
    end
    send_request(connect_item(first, first + 1, 1'b1));
    send_request(connect_item(first + 1, first, 1'b0));
  endtask

  // The result side stops for a long stretch while connects keep coming,
  // so the walk stalls and the request side backs up behind it.
  task automatic test_result_backpressure();
    int unsigned longest;
    longest = shadow_closed - 2;
    hold_requests++;
    send_request(connect_item(longest, longest + 1, 1'b0));
    send_request(connect_item(0, 1, 1'b0));
    send_request(connect_item(longest + 1, longest, 1'b1));
    send_request(connect_item(2, 2, 1'b1));
    send_request(connect_item(0, 2, 1'b0));
  endtask

  // Mostly well-formed traffic: profiles of random length (a few at the
  // limit) grow between connects over stored profiles, with connects that
  // name undefined or identical profiles mixed in. Two profile slots are
  // kept back for the limit test at the end.
  task automatic test_random_traffic(input int unsigned count);
    int unsigned target_len, pa, pb;
    logic closes;
    target_len = 0;
    repeat (count) begin
      if (shadow_closed < MAX_PROFILES - 2 && $urandom_range(0, 99) < 60) begin
        if (target_len == 0)
          target_len = ($urandom_range(0, 9) == 0) ? MAX_PROFILE_VERTICES
                                                   : $urandom_range(1, 6);
        closes = (shadow_open_len + 1 >= target_len);
        send_request(append_item(draw_vertex(), closes));
        if (closes) target_len = 0;
      end else begin
        if (shadow_closed != 0 && $urandom_range(0, 7) != 0) begin
          pa = $urandom_range(0, shadow_closed - 1);
          pb = ($urandom_range(0, 7) == 0) ? pa : $urandom_range(0, shadow_closed - 1);
        end else begin
          pa = $urandom_range(0, 31);
          pb = $urandom_range(0, 31);
        end
        send_request(connect_item(pa, pb, 1'($urandom)));
      end
    end
  endtask

  // Fills the profile table to its last slot, then fills one more profile
  // to the length limit. Either that profile stays open and the next
  // appends overflow on length, or it closes and they overflow on the
  // profile count. The seed picks which.
  task automatic test_store_limits();
    int unsigned n;
    logic close_last;
    while (shadow_closed < MAX_PROFILES - 1)
      send_request(append_item(draw_vertex(), 1'b1));
    close_last = 1'($urandom);
    for (n = 0; n < MAX_PROFILE_VERTICES; n++)
      send_request(append_item(draw_vertex(), close_last && n == MAX_PROFILE_VERTICES - 1));
    send_request(append_item(draw_vertex(), 1'b1));
    send_request(append_item(pst_pkg::VERTEX_W'($urandom), 1'b0));
    send_request(connect_item(MAX_PROFILES - 1, 0, 1'b1));
    send_request(connect_item(MAX_PROFILES - 2, MAX_PROFILES - 1, 1'b0));
    send_request(connect_item(0, MAX_PROFILES - 2, 1'b1));
    send_request(append_item(draw_vertex(), 1'b1));
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    req_ch.valid          = 1'b0;
    req_ch.operation      = pst_pkg::OP_APPEND;
    req_ch.vertex_index   = '0;
    req_ch.closes_profile = 1'b0;
    req_ch.profile_a      = '0;
    req_ch.profile_b      = '0;
    req_ch.even_pattern   = 1'b0;
    shadow_start[0]       = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_undefined_before_profiles();
    test_small_strips();
    test_longest_walk();
    test_result_backpressure();
    test_random_traffic(RANDOM_REQUESTS);
    test_store_limits();
    await_drain();

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Several times the slowest legal run: every connect returning 62
  // results, each one behind the longest result stall.
  initial begin : watchdog
    #30_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
